// ===== rtl/core/rrtr_pkg.sv =====
// shared types and codes for the round-robin thread ring
package rrtr_pkg;

	typedef enum logic [1:0] {
		ACT_ADMIT  = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_NEXT   = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_DUP    = 2'd1,
		STAT_ABSENT = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_EXEC  = 2'd1,
		S_LINK2 = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic link2;
	} cmd_t;

	typedef struct packed {
		logic rsp_free;
		logic need_link2;
	} sts_t;

endpackage

// ===== rtl/core/rrtr_req_if.sv =====
// request channel: action and thread id
interface rrtr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] thread_id;

	modport source (output valid, output action, output thread_id, input ready);
	modport sink (input valid, input action, input thread_id, output ready);
endinterface

// ===== rtl/core/rrtr_rsp_if.sv =====
// result channel: status, selection and ready count
interface rrtr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] selected_id;
	logic       selected_valid;
	logic [4:0] ready_count;

	modport source (output valid, output status, output selected_id,
		output selected_valid, output ready_count, input ready);
	modport sink (input valid, input status, input selected_id,
		input selected_valid, input ready_count, output ready);
endinterface

// ===== rtl/core/rrtr_ram.sv =====
// generic single write port ram with registered read
module rrtr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/rrtr_ctrl.sv =====
// controller state machine: accept, update, second link write
module rrtr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rrtr_pkg::sts_t sts,
	output rrtr_pkg::cmd_t cmd
);
	import rrtr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.rsp_free) begin
					cmd.exec = 1'b1;
					state_d  = sts.need_link2 ? S_LINK2 : S_IDLE;
				end
			end
			S_LINK2: begin
				cmd.link2 = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/rrtr_dp.sv =====
// datapath: link rams, membership flags, ring registers and result register
module rrtr_dp #(
	parameter int MAX_THREADS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rrtr_pkg::cmd_t cmd,
	output rrtr_pkg::sts_t sts,
	input  logic [1:0]     req_action,
	input  logic [3:0]     req_thread_id,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output logic [1:0]     rsp_status,
	output logic [3:0]     rsp_selected_id,
	output logic           rsp_selected_valid,
	output logic [4:0]     rsp_ready_count
);
	import rrtr_pkg::*;

	localparam int IDW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW  = $clog2(MAX_THREADS + 1);

	logic [1:0]             action_q;
	logic [3:0]             id_q;
	logic [IDW-1:0]         head_q;
	logic [IDW-1:0]         current_q;
	logic                   started_q;
	logic [CW-1:0]          count_q;
	logic [MAX_THREADS-1:0] member_q;

	logic                   rsp_valid_q;
	stat_t                  rsp_status_q;
	logic [3:0]             rsp_sel_q;
	logic                   rsp_sel_valid_q;
	logic [4:0]             rsp_count_q;

	logic [IDW-1:0]         head_d;
	logic [IDW-1:0]         current_d;
	logic                   started_d;
	logic [CW-1:0]          count_d;
	logic [MAX_THREADS-1:0] member_d;
	stat_t                  status_d;
	logic [3:0]             sel_d;
	logic                   sel_valid_d;

	logic [IDW-1:0]         slot;
	logic [IDW-1:0]         req_slot;
	logic                   id_ok;
	logic                   is_member;
	logic                   count_zero;
	logic                   count_one;

	logic                   succ_we;
	logic [IDW-1:0]         succ_waddr;
	logic [IDW-1:0]         succ_wdata;
	logic [IDW-1:0]         succ_raddr;
	logic [IDW-1:0]         succ_rdata;
	logic                   pred_we;
	logic [IDW-1:0]         pred_waddr;
	logic [IDW-1:0]         pred_wdata;
	logic [IDW-1:0]         pred_raddr;
	logic [IDW-1:0]         pred_rdata;

	assign slot       = IDW'(id_q);
	assign req_slot   = IDW'(req_thread_id);
	assign id_ok      = int'(id_q) < MAX_THREADS;
	assign is_member  = id_ok && member_q[slot];
	assign count_zero = (count_q == '0);
	assign count_one  = (count_q == CW'(1));

	// links needed by the item are fetched in the accept cycle
	assign succ_raddr = (req_action == ACT_REMOVE) ? req_slot : current_q;
	assign pred_raddr = (req_action == ACT_REMOVE) ? req_slot : head_q;

	rrtr_ram #(
		.WIDTH(IDW),
		.DEPTH(MAX_THREADS)
	) u_succ_ram (
		.clk   (clk),
		.we    (succ_we),
		.waddr (succ_waddr),
		.wdata (succ_wdata),
		.re    (cmd.accept),
		.raddr (succ_raddr),
		.rdata (succ_rdata)
	);

	rrtr_ram #(
		.WIDTH(IDW),
		.DEPTH(MAX_THREADS)
	) u_pred_ram (
		.clk   (clk),
		.we    (pred_we),
		.waddr (pred_waddr),
		.wdata (pred_wdata),
		.re    (cmd.accept),
		.raddr (pred_raddr),
		.rdata (pred_rdata)
	);

	assign sts.rsp_free   = !rsp_valid_q || rsp_ready;
	assign sts.need_link2 = (action_q == ACT_ADMIT) && id_ok && !is_member && !count_zero;

	always_comb begin
		head_d      = head_q;
		current_d   = current_q;
		started_d   = started_q;
		count_d     = count_q;
		member_d    = member_q;
		status_d    = STAT_OK;
		sel_d       = 4'd0;
		sel_valid_d = 1'b0;
		succ_we     = 1'b0;
		succ_waddr  = slot;
		succ_wdata  = slot;
		pred_we     = 1'b0;
		pred_waddr  = slot;
		pred_wdata  = slot;
		if (cmd.link2) begin
			// tail now points to the new entry, head points back to it
			succ_we    = 1'b1;
			succ_waddr = pred_rdata;
			succ_wdata = slot;
			pred_we    = 1'b1;
			pred_waddr = head_q;
			pred_wdata = slot;
		end else if (cmd.exec) begin
			unique case (action_q)
				ACT_ADMIT: begin
					if (!id_ok) begin
						status_d = STAT_ABSENT;
					end else if (is_member) begin
						status_d = STAT_DUP;
					end else begin
						member_d[slot] = 1'b1;
						count_d        = count_q + CW'(1);
						succ_we        = 1'b1;
						pred_we        = 1'b1;
						if (count_zero) begin
							head_d = slot;
						end else begin
							succ_wdata = head_q;
							pred_wdata = pred_rdata;
						end
					end
				end
				ACT_REMOVE: begin
					if (!is_member) begin
						status_d = STAT_ABSENT;
					end else begin
						member_d[slot] = 1'b0;
						if (count_zero || count_one) begin
							head_d    = '0;
							current_d = '0;
							started_d = 1'b0;
							count_d   = '0;
						end else begin
							succ_we    = 1'b1;
							succ_waddr = pred_rdata;
							succ_wdata = succ_rdata;
							pred_we    = 1'b1;
							pred_waddr = succ_rdata;
							pred_wdata = pred_rdata;
							if (head_q == slot) begin
								head_d = succ_rdata;
							end
							if (started_q && current_q == slot) begin
								current_d = pred_rdata;
							end
							count_d = count_q - CW'(1);
						end
					end
				end
				ACT_NEXT: begin
					if (count_zero) begin
						started_d = 1'b0;
						current_d = '0;
					end else begin
						started_d   = 1'b1;
						current_d   = started_q ? succ_rdata : head_q;
						sel_d       = 4'(current_d);
						sel_valid_d = 1'b1;
					end
				end
				default: begin
					status_d = STAT_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			current_q   <= '0;
			started_q   <= 1'b0;
			count_q     <= '0;
			member_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q      <= head_d;
				current_q   <= current_d;
				started_q   <= started_d;
				count_q     <= count_d;
				member_q    <= member_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= req_action;
			id_q     <= req_thread_id;
		end
		if (cmd.exec) begin
			rsp_status_q    <= status_d;
			rsp_sel_q       <= sel_d;
			rsp_sel_valid_q <= sel_valid_d;
			rsp_count_q     <= 5'(count_d);
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign rsp_status         = rsp_status_q;
	assign rsp_selected_id    = rsp_sel_q;
	assign rsp_selected_valid = rsp_sel_valid_q;
	assign rsp_ready_count    = rsp_count_q;
endmodule

// ===== rtl/core/round_robin_thread_ring_unit.sv =====
// Round-robin ring of ready thread IDs with admit, remove and pick-next
// actions. Each request item gives exactly one result item. An item is
// first read, fetching the predecessor and successor links from the link
// RAMs, then updated, changing the ring and loading the result register.
// Admitting into a non-empty ring adds a second link write step, because
// each link RAM has a single write port and the admit changes two entries
// of each. The next item is accepted only once the update is finished, so
// a new item is never taken before the last one is through. The result
// register holds a finished result while a new item is taken; if it is
// still full when the next update is due, the update waits.
// The link RAMs need no clearing after reset.
module round_robin_thread_ring_unit #(
	parameter int MAX_THREADS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rrtr_req_if.sink    req,
	rrtr_rsp_if.source  rsp
);
	import rrtr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rrtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrtr_dp #(
		.MAX_THREADS(MAX_THREADS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.req_action         (req.action),
		.req_thread_id      (req.thread_id),
		.rsp_valid          (rsp.valid),
		.rsp_ready          (rsp.ready),
		.rsp_status         (rsp.status),
		.rsp_selected_id    (rsp.selected_id),
		.rsp_selected_valid (rsp.selected_valid),
		.rsp_ready_count    (rsp.ready_count)
	);
endmodule

// ===== tb/rrtr_ring_checker.sv =====
// checker for the thread ring: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module rrtr_ring_checker (
	input  logic clk,
	input  logic arst_n,
	rrtr_req_if  req,
	rrtr_rsp_if  rsp,
	output int   failures,
	output int   pending
);
	import rrtr_pkg::*;

	localparam int N_IDS = 16;

	typedef struct {
		stat_t      status;
		logic [3:0] sel;
		logic       selv;
		logic [4:0] cnt;
	} ring_answer_t;

	logic [3:0] link_fwd [N_IDS];
	logic [3:0] link_back [N_IDS];
	logic       listed [N_IDS];
	logic [3:0] head_id;
	logic [3:0] pick_id;
	logic       picking;
	logic [4:0] ring_count;

	ring_answer_t awaited_answers [$];

	function automatic void log_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic ring_answer_t predict_ring_action(logic [1:0] act, logic [3:0] id);
		ring_answer_t ans;
		logic [3:0] tail;
		logic [3:0] prev_id;
		logic [3:0] next_id;
		ans.status = STAT_OK;
		ans.sel = '0;
		ans.selv = 1'b0;
		case (act)
			ACT_ADMIT: begin
				if (listed[id]) begin
					ans.status = STAT_DUP;
				end else begin
					if (ring_count == 0) begin
						head_id = id;
						link_fwd[id] = id;
						link_back[id] = id;
					end else begin
						tail = link_back[head_id];
						link_fwd[id] = head_id;
						link_back[id] = tail;
						link_fwd[tail] = id;
						link_back[head_id] = id;
					end
					listed[id] = 1'b1;
					ring_count++;
				end
			end
			ACT_REMOVE: begin
				if (!listed[id]) begin
					ans.status = STAT_ABSENT;
				end else begin
					listed[id] = 1'b0;
					if (ring_count <= 1) begin
						head_id = '0;
						pick_id = '0;
						picking = 1'b0;
						ring_count = '0;
					end else begin
						prev_id = link_back[id];
						next_id = link_fwd[id];
						if (head_id == id)
							head_id = next_id;
						link_fwd[prev_id] = next_id;
						link_back[next_id] = prev_id;
						// removing the current entry steps back so the successor comes next
						if (picking && pick_id == id)
							pick_id = prev_id;
						ring_count--;
					end
				end
			end
			ACT_NEXT: begin
				if (ring_count == 0) begin
					picking = 1'b0;
					pick_id = '0;
				end else begin
					if (!picking) begin
						picking = 1'b1;
						pick_id = head_id;
					end else begin
						pick_id = link_fwd[pick_id];
					end
					ans.sel = pick_id;
					ans.selv = 1'b1;
				end
			end
			default: ;
		endcase
		ans.cnt = ring_count;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < N_IDS; i++)
				listed[i] <= 1'b0;
			head_id <= '0;
			pick_id <= '0;
			picking <= 1'b0;
			ring_count <= '0;
			awaited_answers.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_answers.size() == 0) begin
					log_failure($sformatf("result item with nothing pending: st %0d sel %0d/%0d cnt %0d",
						rsp.status, rsp.selected_valid, rsp.selected_id, rsp.ready_count));
				end else begin
					want = awaited_answers.pop_front();
					if (rsp.status !== want.status || rsp.selected_id !== want.sel ||
						rsp.selected_valid !== want.selv || rsp.ready_count !== want.cnt)
						log_failure($sformatf(
							"mismatch: exp st %0d sel %0d/%0d cnt %0d, got st %0d sel %0d/%0d cnt %0d",
							want.status, want.selv, want.sel, want.cnt, rsp.status,
							rsp.selected_valid, rsp.selected_id, rsp.ready_count));
				end
			end
			if (req.valid && req.ready)
				awaited_answers.push_back(predict_ring_action(req.action, req.thread_id));
			pending <= awaited_answers.size();
		end
	end

endmodule

// ===== tb/round_robin_thread_ring_unit_tb.sv =====
// top of the thread ring testbench: clock, reset, request and result traffic, verdict
`timescale 1ns / 1ps

module round_robin_thread_ring_unit_tb;
	import rrtr_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic quiet;
	int   failures;
	int   pending;

	rrtr_req_if req_ch ();
	rrtr_rsp_if rsp_ch ();

	round_robin_thread_ring_unit #(
		.MAX_THREADS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	rrtr_ring_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("round_robin_thread_ring_unit_tb: done, errors");
		$finish;
	end

	task automatic send_request(input logic [1:0] act, input logic [3:0] id);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.thread_id <= id;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// result side: random stall before each item
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			repeat (stall) begin
				rsp_ch.ready <= 1'b0;
				@(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin
		int mode;
		int r;
		int admit_pct;
		int remove_pct;
		logic [1:0] act;
		arst_n = 1'b0;
		quiet = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ADMIT;
		req_ch.thread_id = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty ring, duplicates, removal of current, head and last entry
		send_request(ACT_NEXT, 4'd3);
		send_request(ACT_REMOVE, 4'd5);
		send_request(ACT_ADMIT, 4'd0);
		send_request(ACT_ADMIT, 4'd15);
		send_request(ACT_ADMIT, 4'd7);
		send_request(ACT_ADMIT, 4'd15);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_REMOVE, 4'd15);
		send_request(ACT_NEXT, 4'd15);
		send_request(ACT_REMOVE, 4'd0);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_UNUSED, 4'd9);
		send_request(ACT_ADMIT, 4'd10);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_REMOVE, 4'd10);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_REMOVE, 4'd7);
		send_request(ACT_NEXT, 4'd0);
		send_request(ACT_REMOVE, 4'd7);
		send_request(ACT_UNUSED, 4'd15);

		// random: phases that fill, drain or churn the ring
		for (int ph = 0; ph < 12; ph++) begin
			mode = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			admit_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 35;
			remove_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 35;
			for (int k = 0; k < 150; k++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					act = ACT_UNUSED;
				else if (r < 2 + admit_pct)
					act = ACT_ADMIT;
				else if (r < 2 + admit_pct + remove_pct)
					act = ACT_REMOVE;
				else
					act = ACT_NEXT;
				send_request(act, 4'($urandom_range(0, 15)));
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("round_robin_thread_ring_unit_tb: done, clean");
		else
			$display("round_robin_thread_ring_unit_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rrtr_pkg.sv
rtl/core/rrtr_req_if.sv
rtl/core/rrtr_rsp_if.sv
rtl/core/rrtr_ram.sv
rtl/core/rrtr_ctrl.sv
rtl/core/rrtr_dp.sv
rtl/core/round_robin_thread_ring_unit.sv
tb/rrtr_ring_checker.sv
tb/round_robin_thread_ring_unit_tb.sv
